>>> hdl/efi_pkg.sv
// Shared types and constants for the escape-time fractal iterator.
// Used by the iteration core, the top level and the testbench.
package efi_pkg;

    localparam int COORD_FRAC_BITS = 28;
    localparam int ESC_EXP = 2 * COORD_FRAC_BITS + 2;
    localparam bit NEVER_ESC = (ESC_EXP >= 64);
    localparam logic [63:0] ESC_LIMIT = NEVER_ESC ? 64'd0 : (64'd1 << ESC_EXP);

    localparam logic [1:0] KIND_MANDEL = 2'd0;
    localparam logic [1:0] KIND_JULIA  = 2'd1;
    localparam logic [1:0] KIND_SHIP   = 2'd2;

    localparam logic [7:0] REG_KIND       = 8'd0;
    localparam logic [7:0] REG_STEP_LIMIT = 8'd1;
    localparam logic [7:0] REG_JC_REAL    = 8'd2;
    localparam logic [7:0] REG_JC_IMAG    = 8'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic [15:0]        step_limit;
        logic signed [31:0] jc_real;
        logic signed [31:0] jc_imag;
    } cfg_t;

    typedef struct packed {
        logic        valid;
        logic [15:0] count;
        logic        escaped;
    } res_t;

endpackage

>>> hdl/efi_mul.sv
// Shared signed 33 x 33 multiplier with a registered product.
// Depends on nothing but the clock.
module efi_mul (
    input  logic               aclk,
    input  logic signed [32:0] a,
    input  logic signed [32:0] b,
    output logic signed [65:0] p_reg
);

    always_ff @(posedge aclk) begin
        p_reg <= a * b;
    end

endmodule

>>> hdl/efi_core.sv
// Iteration sequencer and datapath around one shared multiplier.
// Depends on efi_pkg and efi_mul.
module efi_core
    import efi_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [31:0] point_real,
    input  logic signed [31:0] point_imag,
    input  cfg_t               cfg,
    input  logic               res_ready,
    output logic               idle,
    output res_t               res
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_SQR_R, ST_SQR_I, ST_CROSS, ST_UPDATE, ST_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic signed [31:0] zr_reg, zr_next, zi_reg, zi_next;
    logic signed [31:0] cr_reg, cr_next, ci_reg, ci_next;
    logic               ship_reg, ship_next;
    logic [15:0]        step_reg, step_next;
    logic [63:0]        sq_r_reg, sq_r_next, sq_i_reg, sq_i_next;
    logic [15:0]        count_reg, count_next;
    logic               esc_reg, esc_next;

    logic signed [32:0] zr_op, zi_op, mul_a, mul_b;
    logic signed [65:0] prod;
    logic [63:0]        mag;
    logic signed [63:0] diff, sh_r, sh_i;
    logic signed [64:0] sum_r, sum_i;
    logic signed [31:0] new_r, new_i;

    function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
        logic signed [31:0] r;
        if (v[64:31] == '0 || v[64:31] == '1) begin
            r = v[31:0];
        end else if (v[64]) begin
            r = {1'b1, 31'd0};
        end else begin
            r = {1'b0, {31{1'b1}}};
        end
        return r;
    endfunction

    efi_mul u_mul (
        .aclk  (aclk),
        .a     (mul_a),
        .b     (mul_b),
        .p_reg (prod)
    );

    always_comb begin
        zr_op = {zr_reg[31], zr_reg};
        zi_op = {zi_reg[31], zi_reg};
        if (ship_reg && zr_reg[31]) begin
            zr_op = -zr_op;
        end
        if (ship_reg && zi_reg[31]) begin
            zi_op = -zi_op;
        end
        case (state_reg)
            ST_SQR_R: begin
                mul_a = zr_op;
                mul_b = zr_op;
            end
            ST_SQR_I: begin
                mul_a = zi_op;
                mul_b = zi_op;
            end
            default: begin
                mul_a = zr_op;
                mul_b = zi_op;
            end
        endcase
    end

    assign mag   = sq_r_reg + prod[63:0];
    assign diff  = $signed(sq_r_reg) - $signed(sq_i_reg);
    assign sh_r  = diff >>> COORD_FRAC_BITS;
    assign sh_i  = $signed(prod[63:0]) >>> (COORD_FRAC_BITS - 1);
    assign sum_r = {sh_r[63], sh_r} + {{33{cr_reg[31]}}, cr_reg};
    assign sum_i = {sh_i[63], sh_i} + {{33{ci_reg[31]}}, ci_reg};
    assign new_r = sat32(sum_r);
    assign new_i = sat32(sum_i);

    always_comb begin
        state_next = state_reg;
        zr_next    = zr_reg;
        zi_next    = zi_reg;
        cr_next    = cr_reg;
        ci_next    = ci_reg;
        ship_next  = ship_reg;
        step_next  = step_reg;
        sq_r_next  = sq_r_reg;
        sq_i_next  = sq_i_reg;
        count_next = count_reg;
        esc_next   = esc_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    ship_next = (cfg.kind == KIND_SHIP);
                    step_next = '0;
                    if (cfg.kind == KIND_JULIA) begin
                        zr_next = point_real;
                        zi_next = point_imag;
                        cr_next = cfg.jc_real;
                        ci_next = cfg.jc_imag;
                    end else begin
                        zr_next = '0;
                        zi_next = '0;
                        cr_next = point_real;
                        ci_next = point_imag;
                    end
                    state_next = ST_SQR_R;
                end
            end
            ST_SQR_R: begin
                state_next = ST_SQR_I;
            end
            ST_SQR_I: begin
                sq_r_next  = prod[63:0];
                state_next = ST_CROSS;
            end
            ST_CROSS: begin
                sq_i_next = prod[63:0];
                if (step_reg != '0 && !NEVER_ESC && mag > ESC_LIMIT) begin
                    count_next = step_reg - 16'd1;
                    esc_next   = 1'b1;
                    state_next = ST_DONE;
                end else if (step_reg == cfg.step_limit) begin
                    count_next = cfg.step_limit;
                    esc_next   = 1'b0;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                zr_next    = new_r;
                zi_next    = new_i;
                step_next  = step_reg + 16'd1;
                state_next = ST_SQR_R;
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        zr_reg    <= zr_next;
        zi_reg    <= zi_next;
        cr_reg    <= cr_next;
        ci_reg    <= ci_next;
        ship_reg  <= ship_next;
        step_reg  <= step_next;
        sq_r_reg  <= sq_r_next;
        sq_i_reg  <= sq_i_next;
        count_reg <= count_next;
        esc_reg   <= esc_next;
    end

    assign idle        = (state_reg == ST_IDLE);
    assign res.valid   = (state_reg == ST_DONE);
    assign res.count   = count_reg;
    assign res.escaped = esc_reg;

endmodule

>>> hdl/escape_time_fractal_iterator_top.sv
// Top level of the escape-time fractal iterator: configuration registers,
// input handshake and output register. Depends on efi_pkg and efi_core.
//
// Usage:
// The s_ channel takes one complex point per item (signed Q4.28 parts).
// The m_ channel returns one item per point: the step index at which
// |z|^2 first exceeded four with m_escaped set, or max_iterations with
// m_escaped clear. The cfg_ channel writes the kind, the step limit and
// the Julia constant; cfg_ready is always high, unknown indexes are dropped.
// One shared multiplier does three products per step, so a step passes
// through ST_SQR_R, ST_SQR_I, ST_CROSS and ST_UPDATE. One point is in
// flight at a time; s_ready is high only while the core is idle, and the
// core returns to idle as the previous result enters the output register.
// A finished result sits in the output register, and the next point is
// accepted while it waits. If the receiver stalls, the core holds its next
// result in ST_DONE until the register frees, accepting no point meanwhile.
// Reset empties the pipeline and restores kind Mandelbrot, a limit of 100
// and a zero Julia constant.
module escape_time_fractal_iterator_top
    import efi_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_point_real,
    input  logic signed [31:0] s_point_imag,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        m_iteration_count,
    output logic               m_escaped,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    cfg_t        cfg_reg;
    logic        m_valid_reg;
    logic [15:0] count_reg;
    logic        esc_reg;
    logic        core_idle;
    logic        out_free;
    res_t        core_res;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = core_idle;

    efi_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (s_valid),
        .point_real (s_point_real),
        .point_imag (s_point_imag),
        .cfg        (cfg_reg),
        .res_ready  (out_free),
        .idle       (core_idle),
        .res        (core_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kind       <= KIND_MANDEL;
            cfg_reg.step_limit <= 16'd100;
            cfg_reg.jc_real    <= '0;
            cfg_reg.jc_imag    <= '0;
            m_valid_reg        <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_KIND:       cfg_reg.kind       <= cfg_data[1:0];
                    REG_STEP_LIMIT: cfg_reg.step_limit <= cfg_data[15:0];
                    REG_JC_REAL:    cfg_reg.jc_real    <= cfg_data;
                    REG_JC_IMAG:    cfg_reg.jc_imag    <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if (out_free) begin
                m_valid_reg <= core_res.valid;
            end
        end
        if (out_free && core_res.valid) begin
            count_reg <= core_res.count;
            esc_reg   <= core_res.escaped;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_iteration_count = count_reg;
    assign m_escaped         = esc_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("core still idle after taking an item");

    a_out_from_core: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(core_res.valid))
        else $error("output register loaded without a core result");

    a_no_lost_result: assert property (@(posedge aclk) disable iff (!aresetn)
        core_res.valid && !out_free |=> core_res.valid)
        else $error("core result dropped while output register full");

endmodule

>>> tb/efi_escape_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the escape-time fractal iterator: follows register writes,
// predicts the iteration count of each accepted point and checks every result.
// Depends on efi_pkg.
module efi_escape_checker
    import efi_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [31:0] s_point_real,
    input  logic signed [31:0] s_point_imag,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [15:0]        m_iteration_count,
    input  logic               m_escaped,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [7:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output int                 fail_count,
    output int                 pending
);

    localparam int REPORT_LIMIT = 10;
    localparam int ESCAPE_EXP = 2 * COORD_FRAC_BITS + 2;
    localparam bit ESCAPE_REACHABLE = (ESCAPE_EXP < 64);
    localparam logic [63:0] ESCAPE_BOUND = ESCAPE_REACHABLE ? (64'd1 << ESCAPE_EXP) : '1;
    localparam longint PART_MAX = 64'sd2147483647;
    localparam longint PART_MIN = -64'sd2147483648;

    typedef struct packed {
        logic [15:0] count;
        logic        escaped;
    } escape_t;

    logic [1:0]         kind_q;
    logic [15:0]        limit_q;
    logic signed [31:0] c_re_q;
    logic signed [31:0] c_im_q;
    escape_t            expected_escapes[$];

    function automatic longint clamp_part(input longint v);
        if (v > PART_MAX)
            return PART_MAX;
        if (v < PART_MIN)
            return PART_MIN;
        return v;
    endfunction

    function automatic escape_t escape_time(input logic [1:0] kind, input logic [15:0] limit,
                                            input logic signed [31:0] c_re_reg,
                                            input logic signed [31:0] c_im_reg,
                                            input logic signed [31:0] p_re,
                                            input logic signed [31:0] p_im);
        longint zr, zi, cr, ci, ar, ai;
        logic [63:0] mag;
        escape_t res;
        res.count = limit;
        res.escaped = 1'b0;
        zr = 0;
        zi = 0;
        cr = p_re;
        ci = p_im;
        if (kind == KIND_JULIA) begin
            zr = p_re;
            zi = p_im;
            cr = c_re_reg;
            ci = c_im_reg;
        end
        for (int iter = 0; iter < int'(limit); iter++) begin
            ar = zr;
            ai = zi;
            if (kind == KIND_SHIP) begin
                if (ar < 0)
                    ar = -ar;
                if (ai < 0)
                    ai = -ai;
            end
            zr = clamp_part(((ar * ar - ai * ai) >>> COORD_FRAC_BITS) + cr);
            zi = clamp_part(((ar * ai) >>> (COORD_FRAC_BITS - 1)) + ci);
            mag = zr * zr + zi * zi;
            if (ESCAPE_REACHABLE && mag > ESCAPE_BOUND) begin
                res.count = 16'(iter);
                res.escaped = 1'b1;
                break;
            end
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        escape_t got;
        escape_t want;
        if (!aresetn) begin
            kind_q <= KIND_MANDEL;
            limit_q <= 16'd100;
            c_re_q <= '0;
            c_im_q <= '0;
            expected_escapes.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_KIND: begin
                        kind_q <= cfg_data[1:0];
                    end
                    REG_STEP_LIMIT: begin
                        limit_q <= cfg_data[15:0];
                    end
                    REG_JC_REAL: begin
                        c_re_q <= cfg_data;
                    end
                    REG_JC_IMAG: begin
                        c_im_q <= cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (s_valid && s_ready)
                expected_escapes.push_back(escape_time(kind_q, limit_q, c_re_q, c_im_q,
                                                       s_point_real, s_point_imag));
            if (m_valid && m_ready) begin
                got.count = m_iteration_count;
                got.escaped = m_escaped;
                if (expected_escapes.size() == 0) begin
                    if (fail_count < REPORT_LIMIT)
                        $display("Unexpected result item: count %0d escaped %0b.",
                                 got.count, got.escaped);
                    fail_count++;
                end else begin
                    want = expected_escapes.pop_front();
                    if (got.count !== want.count || got.escaped !== want.escaped) begin
                        if (fail_count < REPORT_LIMIT)
                            $display({"Mismatch: expected count %0d escaped %0b, ",
                                      "got count %0d escaped %0b."},
                                     want.count, want.escaped, got.count, got.escaped);
                        fail_count++;
                    end
                end
            end
        end
        pending = expected_escapes.size();
    end

endmodule

>>> tb/tb_escape_time_fractal_iterator_top.sv
`timescale 1ns / 100ps
// Testbench top for the escape-time fractal iterator: clock, reset, point and
// register stimulus, receiver stalls and the verdict.
// Depends on efi_pkg, escape_time_fractal_iterator_top and efi_escape_checker.
module tb_escape_time_fractal_iterator_top
    import efi_pkg::*;
;

    localparam int CLK_PERIOD = 4;
    localparam int RESET_CYCLES = 7;
    localparam int Q_ONE = 1 << COORD_FRAC_BITS;
    localparam int Q_MAX = 2147483647;
    localparam int Q_MIN = -2147483647 - 1;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [7:0] REG_PAST_END = 8'd4;
    localparam logic [7:0] REG_TOP_INDEX = 8'hFF;
    localparam int IDLE_PERCENT = 36;
    localparam int HOLD_CYCLES = 600;
    localparam int WATCHDOG_LIMIT = 1_200_000;
    localparam int SETTLE_CYCLES = 64;
    localparam int PHASES = 7;
    localparam int PHASE_POINTS = 100;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic signed [31:0] s_point_real;
    logic signed [31:0] s_point_imag;
    logic               m_valid;
    logic               m_ready;
    logic [15:0]        m_iteration_count;
    logic               m_escaped;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [7:0]         cfg_index;
    logic [31:0]        cfg_data;
    int                 fail_count;
    int                 pending;
    int                 idle_cycles;
    bit                 calm;
    bit                 hold_request;
    logic [1:0]         phase_kind;
    logic [15:0]        phase_limit;

    escape_time_fractal_iterator_top dut (.*);

    efi_escape_checker u_escape_check (.*);

    initial aclk = 1'b0;
    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_request = 1'b0;
                m_ready <= 1'b1;
            end else begin
                m_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    task automatic write_reg(input logic [7:0] idx, input logic [31:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_config(input logic [1:0] kind, input logic [15:0] limit,
                              input int c_re, input int c_im);
        write_reg(REG_KIND, {30'd0, kind});
        write_reg(REG_STEP_LIMIT, {16'd0, limit});
        write_reg(REG_JC_REAL, 32'(c_re));
        write_reg(REG_JC_IMAG, 32'(c_im));
    endtask

    task automatic send_point(input int re, input int im);
        while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_point_real <= re;
        s_point_imag <= im;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    function automatic int random_coord();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return int'($urandom_range(5 * Q_ONE)) - 5 * Q_ONE / 2;
        if (pick < 90)
            return int'($urandom);
        case ($urandom_range(5))
            0: return 0;
            1: return Q_MAX;
            2: return Q_MIN;
            3: return 2 * Q_ONE;
            4: return -2 * Q_ONE;
            default: return Q_ONE / 4;
        endcase
    endfunction

    function automatic int random_julia();
        if ($urandom_range(1) == 0)
            return int'($urandom_range(2 * Q_ONE)) - Q_ONE;
        return int'($urandom);
    endfunction

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_point_real = '0;
        s_point_imag = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        calm = 1'b0;
        hold_request = 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        set_config(KIND_MANDEL, 16'd100, 0, 0);
        send_point(0, 0);
        send_point(Q_MAX, Q_MAX);
        send_point(Q_MIN, Q_MIN);
        send_point(-2 * Q_ONE, 0);
        send_point(Q_ONE / 4, 0);
        send_point(Q_ONE, 0);
        send_point(-Q_ONE, 0);
        send_point(0, Q_ONE);
        send_point(Q_MAX, Q_MIN);
        drain();

        // Writes past the last register are dropped, as are data bits above a register's width.
        write_reg(REG_PAST_END, 32'hFFFF_FFFF);
        write_reg(REG_TOP_INDEX, 32'h0000_0001);
        write_reg(REG_KIND, 32'hFFFF_FFF6);
        write_reg(REG_STEP_LIMIT, 32'hABCD_0014);
        send_point(-7 * Q_ONE / 4, -Q_ONE / 32);
        send_point(Q_MIN, 0);
        drain();

        set_config(KIND_UNUSED, 16'd30, 0, 0);
        send_point(Q_ONE / 4, Q_ONE / 2);
        send_point(Q_MAX, 0);
        drain();

        set_config(KIND_JULIA, 16'd64, -(4 * Q_ONE / 5), Q_ONE / 6);
        send_point(0, 0);
        send_point(Q_ONE / 2, Q_ONE / 4);
        send_point(3 * Q_ONE / 2, -3 * Q_ONE / 2);
        send_point(Q_MAX, Q_MIN);
        drain();

        set_config(KIND_JULIA, 16'd40, Q_MAX, Q_MIN);
        send_point(0, 0);
        send_point(Q_MIN, Q_MAX);
        drain();

        set_config(KIND_MANDEL, 16'd0, 0, 0);
        send_point(Q_MAX, Q_MAX);
        drain();

        set_config(KIND_MANDEL, 16'hFFFF, 0, 0);
        send_point(Q_ONE, 0);
        send_point(0, 0);
        drain();

        for (int phase = 0; phase < PHASES; phase++) begin
            phase_kind = 2'(phase);
            phase_limit = 16'($urandom_range(48, 4));
            set_config(phase_kind, phase_limit, random_julia(), random_julia());
            write_reg(8'($urandom_range(255, 4)), $urandom);
            calm = (phase == 3);
            for (int n = 0; n < PHASE_POINTS; n++) begin
                if (phase == 1 && n == 20)
                    hold_request = 1'b1;
                send_point(random_coord(), random_coord());
            end
            drain();
        end
        calm = 1'b0;

        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> files.f
hdl/efi_pkg.sv
hdl/efi_mul.sv
hdl/efi_core.sv
hdl/escape_time_fractal_iterator_top.sv
tb/efi_escape_checker.sv
tb/tb_escape_time_fractal_iterator_top.sv
